### hdl/bcp_pkg.sv
// Shared types, codes and constants of the binomial call pricer.
// Used by bcp_datapath, bcp_controller and the top level.
package bcp_pkg;

  localparam int MAX_STEPS_DEF = 64;
  localparam int DIV_ITERS     = 64;

  localparam logic [1:0] CFG_UP    = 2'd0;
  localparam logic [1:0] CFG_DOWN  = 2'd1;
  localparam logic [1:0] CFG_RATE  = 2'd2;
  localparam logic [1:0] CFG_STEPS = 2'd3;

  localparam logic [31:0] UP_RST    = 32'd1181116006;
  localparam logic [31:0] DOWN_RST  = 32'd966367641;
  localparam logic [31:0] RATE_RST  = 32'd0;
  localparam logic [6:0]  STEPS_RST = 7'd1;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_FACTORS = 2'd1;
  localparam logic [1:0] ST_PROB_RANGE  = 2'd2;

  localparam logic [47:0] V_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] V_MIN   = 48'h8000_0000_0000;
  localparam logic [33:0] P_MAX   = 34'h1_FFFF_FFFF;
  localparam logic [33:0] P_MIN   = 34'h2_0000_0000;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  typedef struct packed {
    logic [39:0] initial_price;
    logic [39:0] strike_price;
  } in_t;

  typedef struct packed {
    logic signed [47:0] option_value;
    logic [1:0]         status;
  } out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIVP_INIT,
    OP_DIVD_INIT,
    OP_DIV_STEP,
    OP_P_SAVE,
    OP_D_SAVE,
    OP_STOCK_INIT,
    OP_MUL_U,
    OP_MUL_D,
    OP_MUL_OMP,
    OP_MUL_P,
    OP_MUL_DISC,
    OP_WR_STOCK,
    OP_WR_PAYOFF,
    OP_HOLD_A,
    OP_ACC,
    OP_WR_VAL,
    OP_OUT,
    OP_OUT_BAD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic bad_factors;
    logic out_full;
  } stat_t;

endpackage

### hdl/binomial_european_call_pricer_core.sv
// CRR binomial European call pricer, one word in, one word out.
// Per word: two serial divides (probability and discount), then the n*(n+3)/2 forward
// nodes, the payoff nodes and the n*(n+1)/2 backward nodes; when u <= d the word goes
// straight to a bad-factors result.
// One word at a time; the next word is taken the cycle after the result is loaded.
// Reset is asynchronous, active low; config returns to its reset values.
module binomial_european_call_pricer_core #(
  parameter int MAX_STEPS = bcp_pkg::MAX_STEPS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bcp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bcp_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i
);
  import bcp_pkg::*;

  localparam int AW = $clog2(MAX_STEPS + 1);

  cmd_t          cmd;
  stat_t         stat;
  logic [AW-1:0] n_steps, addr_a, addr_b;

  bcp_controller #(.MAX_STEPS(MAX_STEPS), .AW(AW)) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .stat_i   (stat),
    .n_i      (n_steps),
    .cmd_o    (cmd),
    .addr_a_o (addr_a),
    .addr_b_o (addr_b)
  );

  bcp_datapath #(.MAX_STEPS(MAX_STEPS), .AW(AW)) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_data_i,
    .cmd_i    (cmd),
    .addr_a_i (addr_a),
    .addr_b_i (addr_b),
    .out_stall_i,
    .stat_o   (stat),
    .n_o      (n_steps),
    .out_valid_o,
    .out_data_o
  );

endmodule

### hdl/bcp_datapath.sv
// Datapath of the binomial call pricer: config registers, lattice memories,
// serial divider, pipelined Q30 multiplier and output word register.
// Depends on bcp_pkg; driven by bcp_controller commands.
module bcp_datapath #(
  parameter int MAX_STEPS = bcp_pkg::MAX_STEPS_DEF,
  parameter int AW        = $clog2(MAX_STEPS + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [31:0]    cfg_data_i,
  input  bcp_pkg::in_t   in_data_i,
  input  bcp_pkg::cmd_t  cmd_i,
  input  logic [AW-1:0]  addr_a_i,
  input  logic [AW-1:0]  addr_b_i,
  input  logic           out_stall_i,
  output bcp_pkg::stat_t stat_o,
  output logic [AW-1:0]  n_o,
  output logic           out_valid_o,
  output bcp_pkg::out_t  out_data_o
);
  import bcp_pkg::*;

  localparam int DEPTH = MAX_STEPS + 1;

  logic [31:0] up_q, dn_q, rate_q;
  logic [6:0]  steps_q;
  logic [39:0] s0_q, k_q;

  logic [47:0] stock_mem [DEPTH];
  logic [47:0] val_mem   [DEPTH];
  logic [47:0] rd_stock_q, rd_va_q, rd_vb_q;

  logic [63:0] dvd_q, quo_q;
  logic [33:0] rem_q;
  logic [32:0] dvs_q;
  logic        neg_q;
  logic [1:0]  status_q;
  logic [33:0] p_q;
  logic [34:0] omp_q;
  logic [31:0] disc_q;

  logic [47:0] a_q, acc_q;

  logic        out_valid_q;
  out_t        out_q;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q    <= UP_RST;
      dn_q    <= DOWN_RST;
      rate_q  <= RATE_RST;
      steps_q <= STEPS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_UP:    up_q    <= cfg_data_i;
        CFG_DOWN:  dn_q    <= cfg_data_i;
        CFG_RATE:  rate_q  <= cfg_data_i;
        CFG_STEPS: steps_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign n_o = (int'(steps_q) > MAX_STEPS) ? AW'(MAX_STEPS) : AW'(steps_q);

  // probability numerator and denominator
  logic [34:0] num_w, mag_w;
  logic [31:0] den_w;
  logic        prob_bad_w;
  logic [32:0] dden_w;

  assign num_w      = {3'b000, ONE_Q30} + {3'b000, rate_q} - {3'b000, dn_q};
  assign mag_w      = num_w[34] ? (35'd0 - num_w) : num_w;
  assign den_w      = up_q - dn_q;
  assign prob_bad_w = num_w[34] || ({3'b000, den_w} < num_w);
  assign dden_w     = {1'b0, ONE_Q30} + {1'b0, rate_q};

  // divider step
  logic [34:0] trial_w;
  logic        qbit_w;
  logic [33:0] rem_next_w;
  assign trial_w    = {rem_q, dvd_q[63]};
  assign qbit_w     = trial_w >= {2'b00, dvs_q};
  assign rem_next_w = qbit_w ? 34'(trial_w - {2'b00, dvs_q}) : trial_w[33:0];

  // saturate the quotient into p
  logic [33:0] p_sat_w;
  always_comb begin
    if (neg_q) begin
      p_sat_w = (quo_q > 64'h2_0000_0000) ? P_MIN : 34'(34'd0 - quo_q[33:0]);
    end else begin
      p_sat_w = (quo_q > {30'd0, P_MAX}) ? P_MAX : quo_q[33:0];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        s0_q <= in_data_i.initial_price;
        k_q  <= in_data_i.strike_price;
      end
      OP_DIVP_INIT: begin
        dvd_q    <= {mag_w[33:0], 30'd0};
        dvs_q    <= {1'b0, den_w};
        rem_q    <= '0;
        quo_q    <= '0;
        neg_q    <= num_w[34];
        status_q <= prob_bad_w ? ST_PROB_RANGE : ST_OK;
      end
      OP_DIVD_INIT: begin
        dvd_q <= (64'd1 << 60) + {32'd0, dden_w[32:1]};
        dvs_q <= dden_w;
        rem_q <= '0;
        quo_q <= '0;
      end
      OP_DIV_STEP: begin
        rem_q <= rem_next_w;
        quo_q <= {quo_q[62:0], qbit_w};
        dvd_q <= {dvd_q[62:0], 1'b0};
      end
      OP_P_SAVE: begin
        p_q   <= p_sat_w;
        omp_q <= {3'b000, ONE_Q30} - {p_sat_w[33], p_sat_w};
      end
      OP_D_SAVE: disc_q <= quo_q[31:0];
      default: ;
    endcase
  end

  // multiplier: five registered stages, m1 to m4 and the result register
  logic [47:0] mul_a;
  logic [34:0] mul_b;
  always_comb begin
    mul_a = rd_stock_q;
    mul_b = {3'b000, up_q};
    case (cmd_i.op)
      OP_MUL_D:    mul_b = {3'b000, dn_q};
      OP_MUL_OMP: begin
        mul_a = rd_va_q;
        mul_b = omp_q;
      end
      OP_MUL_P: begin
        mul_a = rd_vb_q;
        mul_b = {p_q[33], p_q};
      end
      OP_MUL_DISC: begin
        mul_a = acc_q;
        mul_b = {3'b000, disc_q};
      end
      default: ;
    endcase
  end

  logic [47:0] m1_ua;
  logic [34:0] m1_ub, m2_ub;
  logic        m1_neg, m2_neg, m3_neg, m4_neg;
  logic [58:0] m2_pl, m3_pl, m3_ph;
  logic [23:0] m2_ah;
  logic [52:0] m4_mag;
  logic [47:0] mul_res_q;
  logic [82:0] full_w;

  assign full_w = {24'd0, m3_pl} + {m3_ph, 24'd0} + (83'd1 << 29);

  always_ff @(posedge clk_i) begin
    m1_ua  <= mul_a[47] ? (48'd0 - mul_a) : mul_a;
    m1_ub  <= mul_b[34] ? (35'd0 - mul_b) : mul_b;
    m1_neg <= mul_a[47] ^ mul_b[34];
    m2_pl  <= 59'(m1_ua[23:0]) * 59'(m1_ub);
    m2_ah  <= m1_ua[47:24];
    m2_ub  <= m1_ub;
    m2_neg <= m1_neg;
    m3_pl  <= m2_pl;
    m3_ph  <= 59'(m2_ah) * 59'(m2_ub);
    m3_neg <= m2_neg;
    m4_mag <= full_w[82:30];
    m4_neg <= m3_neg;
    if (m4_neg) begin
      mul_res_q <= (m4_mag > (53'd1 << 47)) ? V_MIN : 48'(48'd0 - m4_mag[47:0]);
    end else begin
      mul_res_q <= (m4_mag > {5'd0, V_MAX}) ? V_MAX : m4_mag[47:0];
    end
  end

  // weighted sum and payoff
  logic [48:0] sum_w, diff_w;
  logic [47:0] sum_sat_w, payoff_w;
  assign sum_w  = {a_q[47], a_q} + {mul_res_q[47], mul_res_q};
  assign diff_w = {rd_stock_q[47], rd_stock_q} - {9'd0, k_q};
  always_comb begin
    if (sum_w[48] != sum_w[47]) begin
      sum_sat_w = sum_w[48] ? V_MIN : V_MAX;
    end else begin
      sum_sat_w = sum_w[47:0];
    end
    payoff_w = (diff_w[48] || diff_w == 49'd0) ? 48'd0 : diff_w[47:0];
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_HOLD_A: a_q   <= mul_res_q;
      OP_ACC:    acc_q <= sum_sat_w;
      default: ;
    endcase
  end

  // lattice memories
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_STOCK_INIT: stock_mem[0] <= {8'd0, s0_q};
      OP_WR_STOCK:   stock_mem[addr_a_i] <= mul_res_q;
      default: ;
    endcase
    rd_stock_q <= stock_mem[addr_a_i];
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_WR_PAYOFF: val_mem[addr_a_i] <= payoff_w;
      OP_WR_VAL:    val_mem[addr_a_i] <= mul_res_q;
      default: ;
    endcase
    rd_va_q <= val_mem[addr_a_i];
    rd_vb_q <= val_mem[addr_b_i];
  end

  // output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_OUT || cmd_i.op == OP_OUT_BAD) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_OUT: begin
        out_q.option_value <= rd_va_q;
        out_q.status       <= status_q;
      end
      OP_OUT_BAD: begin
        out_q.option_value <= '0;
        out_q.status       <= ST_BAD_FACTORS;
      end
      default: ;
    endcase
  end

  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;
  assign stat_o.bad_factors = up_q <= dn_q;
  assign stat_o.out_full    = out_valid_q;

endmodule

### hdl/bcp_controller.sv
// Sequencer of the binomial call pricer: divides, forward stock lattice,
// payoffs, backward induction and result hand-off. Depends on bcp_pkg.
module bcp_controller #(
  parameter int MAX_STEPS = bcp_pkg::MAX_STEPS_DEF,
  parameter int AW        = $clog2(MAX_STEPS + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bcp_pkg::stat_t stat_i,
  input  logic [AW-1:0]  n_i,
  output bcp_pkg::cmd_t  cmd_o,
  output logic [AW-1:0]  addr_a_o,
  output logic [AW-1:0]  addr_b_o
);
  import bcp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DIVP, S_PSAVE, S_DINIT, S_DIVD, S_DSAVE,
    S_SINIT, S_STOCK, S_PAY, S_BACK, S_FIN
  } state_e;

  // phases within one node; each multiplier result is used once it has left the multiplier
  localparam logic [5:0] PH_RD     = 6'd0;
  localparam logic [5:0] PH_MUL    = 6'd1;
  localparam logic [5:0] PH_MUL2   = 6'd2;
  localparam logic [5:0] PH_WR_S   = 6'd6;
  localparam logic [5:0] PH_HOLD   = 6'd6;
  localparam logic [5:0] PH_ACC    = 6'd7;
  localparam logic [5:0] PH_DISC   = 6'd8;
  localparam logic [5:0] PH_WR_V   = 6'd13;
  localparam logic [5:0] PH_DIVEND = 6'(DIV_ITERS - 1);

  state_e        state_q, state_d;
  logic [5:0]    ph_q, ph_d;
  logic [AW-1:0] level_q, level_d, node_q, node_d;
  logic          bad_q, bad_d;

  always_comb begin
    state_d  = state_q;
    ph_d     = ph_q;
    level_d  = level_q;
    node_d   = node_q;
    bad_d    = bad_q;
    cmd_o.op = OP_NONE;
    addr_a_o = node_q;
    addr_b_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        ph_d = '0;
        if (stat_i.bad_factors) begin
          bad_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          bad_d    = 1'b0;
          cmd_o.op = OP_DIVP_INIT;
          state_d  = S_DIVP;
        end
      end
      S_DIVP, S_DIVD: begin
        cmd_o.op = OP_DIV_STEP;
        if (ph_q == PH_DIVEND) begin
          ph_d    = '0;
          state_d = (state_q == S_DIVP) ? S_PSAVE : S_DSAVE;
        end else begin
          ph_d = ph_q + 6'd1;
        end
      end
      S_PSAVE: begin
        cmd_o.op = OP_P_SAVE;
        state_d  = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.op = OP_DIVD_INIT;
        state_d  = S_DIVD;
      end
      S_DSAVE: begin
        cmd_o.op = OP_D_SAVE;
        state_d  = S_SINIT;
      end
      S_SINIT: begin
        cmd_o.op = OP_STOCK_INIT;
        level_d  = '0;
        ph_d     = '0;
        if (n_i == '0) begin
          node_d  = '0;
          state_d = S_PAY;
        end else begin
          node_d  = AW'(1);
          state_d = S_STOCK;
        end
      end
      S_STOCK: begin
        // node zero takes the down move, the rest the up move from below
        addr_a_o = (ph_q == PH_WR_S) ? node_q :
                   ((node_q == '0) ? '0 : node_q - AW'(1));
        ph_d = ph_q + 6'd1;
        if (ph_q == PH_MUL) begin
          cmd_o.op = (node_q == '0) ? OP_MUL_D : OP_MUL_U;
        end else if (ph_q == PH_WR_S) begin
          cmd_o.op = OP_WR_STOCK;
          ph_d     = '0;
          if (node_q != '0) begin
            node_d = node_q - AW'(1);
          end else if (level_q + AW'(1) == n_i) begin
            state_d = S_PAY;
          end else begin
            level_d = level_q + AW'(1);
            node_d  = level_q + AW'(2);
          end
        end
      end
      S_PAY: begin
        if (ph_q == PH_RD) begin
          ph_d = PH_MUL;
        end else begin
          cmd_o.op = OP_WR_PAYOFF;
          ph_d     = '0;
          if (node_q == n_i) begin
            node_d  = '0;
            level_d = n_i;
            state_d = (n_i == '0) ? S_FIN : S_BACK;
          end else begin
            node_d = node_q + AW'(1);
          end
        end
      end
      S_BACK: begin
        addr_b_o = node_q + AW'(1);
        ph_d     = ph_q + 6'd1;
        if (ph_q == PH_MUL) begin
          cmd_o.op = OP_MUL_OMP;
        end else if (ph_q == PH_MUL2) begin
          cmd_o.op = OP_MUL_P;
        end else if (ph_q == PH_HOLD) begin
          cmd_o.op = OP_HOLD_A;
        end else if (ph_q == PH_ACC) begin
          cmd_o.op = OP_ACC;
        end else if (ph_q == PH_DISC) begin
          cmd_o.op = OP_MUL_DISC;
        end else if (ph_q == PH_WR_V) begin
          cmd_o.op = OP_WR_VAL;
          ph_d     = '0;
          if (node_q == level_q - AW'(1)) begin
            node_d  = '0;
            level_d = level_q - AW'(1);
            if (level_q == AW'(1)) begin
              state_d = S_FIN;
            end
          end else begin
            node_d = node_q + AW'(1);
          end
        end
      end
      S_FIN: begin
        addr_a_o = '0;
        if (ph_q == PH_RD) begin
          ph_d = PH_MUL;
        end else if (!stat_i.out_full) begin
          cmd_o.op = bad_q ? OP_OUT_BAD : OP_OUT;
          ph_d     = '0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= '0;
      level_q <= '0;
      node_q  <= '0;
      bad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      level_q <= level_d;
      node_q  <= node_d;
      bad_q   <= bad_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

### tb/sv/binomial_european_call_pricer_core_tb.sv
// Self-checking testbench for binomial_european_call_pricer_core.
// Drives price/strike words, predicts the lattice price in place, and checks each result word.
// Depends on bcp_pkg and the core RTL.
`timescale 1ns / 1ps

module binomial_european_call_pricer_core_tb;
  import bcp_pkg::*;

  localparam int MAXN = 64;
  localparam longint CYCLE_LIMIT = 5_000_000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_t in_data;
  out_t out_data;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [31:0] cfg_data;

  logic [31:0] up_q30, down_q30, rate_q30;
  logic [6:0] nsteps;

  out_t price_fifo[$];
  int errors, prices_seen, words_sent;
  longint cycles;

  binomial_european_call_pricer_core i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[binomial_european_call_pricer_core] ERROR");
      $finish;
    end
  end

  function automatic logic signed [47:0] sat48(logic signed [63:0] x);
    if (x > 64'sh7FFF_FFFF_FFFF) return V_MAX;
    if (x < -64'sh8000_0000_0000) return V_MIN;
    return x[47:0];
  endfunction

  // round-half-away multiply by a Q30 factor, saturate to 48 bits
  function automatic logic signed [47:0] mul_q30(logic signed [47:0] a,
                                                 logic signed [34:0] b);
    logic signed [95:0] prod;
    logic [95:0] mag;
    logic [95:0] q;
    prod = 96'(a) * 96'(b);
    mag = prod < 0 ? -prod : prod;
    q = (mag + (96'd1 << 29)) >> 30;
    if (prod < 0) begin
      if (q > (96'd1 << 47)) return V_MIN;
      return -48'(q);
    end
    if (q > 96'h7FFF_FFFF_FFFF) return V_MAX;
    return q[47:0];
  endfunction

  function automatic out_t price_call(in_t w);
    out_t r;
    logic signed [47:0] stock[MAXN+1];
    logic signed [47:0] val[MAXN+1];
    logic signed [63:0] num, diff;
    logic [63:0] den, mag, q, dden;
    logic [127:0] big;
    logic signed [34:0] prob, omp;
    logic [31:0] disc;
    int n;
    r.status = ST_OK;
    r.option_value = '0;
    if (up_q30 <= down_q30) begin
      r.status = ST_BAD_FACTORS;
      return r;
    end
    n = nsteps > MAXN ? MAXN : nsteps;
    den = up_q30 - down_q30;
    num = (64'sd1 << 30) + $signed({32'd0, rate_q30}) - $signed({32'd0, down_q30});
    if (num < 0 || num > $signed(den)) r.status = ST_PROB_RANGE;
    mag = num < 0 ? -num : num;
    q = (mag << 30) / den;
    if (num < 0) prob = q > (64'd1 << 33) ? -(35'sd1 <<< 33) : -35'(q);
    else prob = q > 64'h1_FFFF_FFFF ? 35'sh1_FFFF_FFFF : 35'(q);
    dden = (64'd1 << 30) + rate_q30;
    big = ((128'd1 << 60) + (dden >> 1)) / dden;
    disc = big[31:0];
    stock[0] = {8'd0, w.initial_price};
    for (int t = 0; t < n; t++) begin
      for (int j = t + 1; j >= 1; j--) stock[j] = mul_q30(stock[j-1], {3'd0, up_q30});
      stock[0] = mul_q30(stock[0], {3'd0, down_q30});
    end
    for (int j = 0; j <= n; j++) begin
      diff = 64'(stock[j]) - $signed({24'd0, w.strike_price});
      val[j] = diff > 0 ? diff[47:0] : '0;
    end
    omp = (35'sd1 <<< 30) - prob;
    for (int t = n; t > 0; t--)
      for (int j = 0; j < t; j++)
        val[j] = mul_q30(sat48(64'(mul_q30(val[j], omp)) + 64'(mul_q30(val[j+1], prob))),
                         {3'd0, disc});
    r.option_value = val[0];
    return r;
  endfunction

  // result side: random stall, compare against the oldest prediction
  initial begin
    out_t e;
    int hold;
    out_stall = 1'b0;
    hold = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        prices_seen++;
        if (price_fifo.size() == 0) begin
          $error("unexpected result word value=%0d status=%0d",
                 out_data.option_value, out_data.status);
          errors++;
        end else begin
          e = price_fifo.pop_front();
          if (out_data.option_value !== e.option_value) begin
            $error("option_value expected %0d got %0d", e.option_value, out_data.option_value);
            errors++;
          end
          if (out_data.status !== e.status) begin
            $error("status expected %0d got %0d", e.status, out_data.status);
            errors++;
          end
        end
      end
      // mostly short stalls, now and then a long one
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
        hold = $urandom_range(20, 80);
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_UP: up_q30 = d;
      CFG_DOWN: down_q30 = d;
      CFG_RATE: rate_q30 = d;
      default: nsteps = d[6:0];
    endcase
  endtask

  // drop valid so the last word is not taken twice, then wait for every result
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (price_fifo.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_model(logic [31:0] u, logic [31:0] d, logic [31:0] r, logic [6:0] n);
    wait_drained();
    write_reg(CFG_UP, u);
    write_reg(CFG_DOWN, d);
    write_reg(CFG_RATE, r);
    write_reg(CFG_STEPS, {25'd0, n});
  endtask

  // hold valid and payload until accepted, then maybe idle
  task automatic send_word(in_t w, out_t exp_word, bit use_exp);
    in_valid <= 1'b1;
    in_data <= w;
    price_fifo.push_back(use_exp ? exp_word : price_call(w));
    do @(posedge clk); while (in_stall);
    words_sent++;
    if ($urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  function automatic logic [39:0] rand_price();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 40'({$urandom(), $urandom()});
      default: return 40'($urandom_range(1, 400)) << 16;
    endcase
  endfunction

  typedef struct {
    logic [39:0] s0;
    logic [39:0] k;
    bit          typed;
    out_t        res;
  } stim_row_t;

  stim_row_t dir_rows[$];

  initial begin
    in_t w;
    out_t bad;
    logic [31:0] u, d, r;
    int ph;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = CFG_UP;
    cfg_data = '0;
    cycles = 0;
    errors = 0;
    up_q30 = UP_RST;
    down_q30 = DOWN_RST;
    rate_q30 = RATE_RST;
    nsteps = STEPS_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset config: zero price, zero strike, extremes
    dir_rows.push_back('{40'd0, 40'd0, 1'b1, '{48'sd0, ST_OK}});
    dir_rows.push_back('{40'd100 << 16, 40'd0, 1'b0, '0});
    dir_rows.push_back('{40'd100 << 16, 40'd100 << 16, 1'b0, '0});
    dir_rows.push_back('{40'd50 << 16, 40'd200 << 16, 1'b1, '{48'sd0, ST_OK}});
    dir_rows.push_back('{'1, 40'd0, 1'b0, '0});
    dir_rows.push_back('{'1, '1, 1'b0, '0});
    dir_rows.push_back('{40'd0, '1, 1'b1, '{48'sd0, ST_OK}});
    dir_rows.push_back('{40'h55_5555_5555, 40'hAA_AAAA_AAAA, 1'b0, '0});
    foreach (dir_rows[i]) begin
      w.initial_price = dir_rows[i].s0;
      w.strike_price = dir_rows[i].k;
      send_word(w, dir_rows[i].res, dir_rows[i].typed);
    end
    // zero steps: intrinsic value
    set_model(UP_RST, DOWN_RST, 32'd0, 7'd0);
    w = '{40'd300 << 16, 40'd100 << 16};
    send_word(w, '{48'sd200 <<< 16, ST_OK}, 1'b1);
    w = '{40'hFF_FFFF_FFFF, 40'd0};
    send_word(w, '{48'sh00FF_FFFF_FFFF, ST_OK}, 1'b1);
    // bad factors: u equal to d, and u below d
    set_model(32'h4000_0000, 32'h4000_0000, 32'd0, 7'd5);
    bad = '{48'sd0, ST_BAD_FACTORS};
    send_word('{40'd100 << 16, 40'd10 << 16}, bad, 1'b1);
    set_model(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd64);
    send_word('{'1, 40'd0}, bad, 1'b1);
    // probability out of range both ways, and saturation
    set_model(32'hFFFF_FFFF, 32'h3000_0000, 32'hFFFF_FFFF, 7'd3);
    send_word('{40'd100 << 16, 40'd1 << 16}, '0, 1'b0);
    send_word('{'1, 40'd0}, '0, 1'b0);
    set_model(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd0, 7'd2);
    send_word('{40'd100 << 16, 40'd90 << 16}, '0, 1'b0);
    // steps above the maximum, and the maximum itself
    set_model(UP_RST, DOWN_RST, 32'd1 << 20, 7'd127);
    send_word('{40'd100 << 16, 40'd100 << 16}, '0, 1'b0);
    set_model(UP_RST, DOWN_RST, 32'd0, 7'd64);
    send_word('{'1, 40'd1}, '0, 1'b0);

    // random phases; most with sane factors and few steps
    for (ph = 0; ph < 18; ph++) begin
      if ($urandom_range(0, 4) == 0) begin
        u = $urandom(); d = $urandom(); r = $urandom();
      end else begin
        u = 32'h4000_0000 + $urandom_range(0, 32'h1000_0000);
        d = 32'h4000_0000 - $urandom_range(1, 32'h1000_0000);
        r = $urandom_range(0, 32'h0080_0000);
      end
      set_model(u, d, r, ph % 6 == 5 ? 7'($urandom_range(40, 127)) : 7'($urandom_range(0, 8)));
      if (ph == 9) wait_drained();
      repeat (ph % 6 == 5 ? 3 : 16) begin
        w.initial_price = rand_price();
        w.strike_price = $urandom_range(0, 1) ? rand_price() : w.initial_price;
        send_word(w, '0, 1'b0);
      end
    end
    in_valid <= 1'b0;

    while (price_fifo.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Priced %0d option words over reset, zero/max/over-max steps, bad factors,",
             words_sent);
    $display("out-of-range probability and %0d random configurations.", 18);
    if (errors == 0) begin
      $display("[binomial_european_call_pricer_core] OK");
    end else begin
      $display("[binomial_european_call_pricer_core] ERROR");
    end
    $finish;
  end

endmodule

### binomial_european_call_pricer_core.f
hdl/bcp_pkg.sv
hdl/bcp_datapath.sv
hdl/bcp_controller.sv
hdl/binomial_european_call_pricer_core.sv
tb/sv/binomial_european_call_pricer_core_tb.sv
